// File: design/ccm_pkg.sv
// shared types, constants and aes helper functions for the ccm cipher unit
// no dependencies; imported by every module of the block
`default_nettype none
package ccm_pkg;

	localparam int BLOCK_BYTES = 16;
	localparam int BLOCK_BITS = BLOCK_BYTES * 8;
	localparam logic [7:0] ADATA_FLAG = 8'h40;
	localparam logic [3:0] SHORT_NONCE = 4'd11;
	localparam logic [3:0] MAX_NONCE = 4'd13;
	localparam logic [3:0] LAST_INDEX = 4'd15;
	localparam logic [4:0] MIN_TAG = 5'd4;
	localparam logic [4:0] MAX_TAG = 5'd16;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_TAG = 2'd2;
	localparam logic [1:0] KIND_STATUS = 2'd3;

	localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
	localparam logic [2:0] CFG_KEY_LOW = 3'd1;
	localparam logic [2:0] CFG_NONCE_HIGH = 3'd2;
	localparam logic [2:0] CFG_NONCE_LOW = 3'd3;
	localparam logic [2:0] CFG_NONCE_LENGTH = 3'd4;
	localparam logic [2:0] CFG_TAG_LENGTH = 3'd5;
	localparam logic [2:0] CFG_HEADER_LENGTH = 3'd6;
	localparam logic [2:0] CFG_PAYLOAD_LENGTH = 3'd7;

	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_kind;
		logic       auth_failed;
		logic       last_of_message;
	} out_t;

	typedef struct packed {
		logic [127:0] key;
		logic [103:0] nonce;
		logic [3:0]   nonce_length;
		logic [4:0]   tag_length;
		logic [15:0]  header_length;
		logic [31:0]  payload_length;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AES_GO,
		ST_AES_WAIT,
		ST_CLASSIFY,
		ST_PAYLOAD,
		ST_EMIT,
		ST_TAG
	} st_t;

	typedef enum logic [1:0] {
		OP_B0,
		OP_A0,
		OP_CTR,
		OP_MAC
	} op_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// one round: sub bytes, shift rows, optional mix columns, add round key
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [7:0]   t [16];
		logic [7:0]   a0, a1, a2, a3, all;
		logic [127:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				t[c*4+j] = SBOX[s[8*(15-(((c+j)%4)*4+j)) +: 8]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c*4];
				a1 = t[c*4+1];
				a2 = t[c*4+2];
				a3 = t[c*4+3];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
				t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
				t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[8*(15-i) +: 8] = t[i];
		end
		return r ^ rk;
	endfunction

	// next round key from the current one
	function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
		logic [31:0] tmp, w0, w1, w2, w3;
		tmp = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
		w0 = rk[127:96] ^ tmp;
		w1 = rk[95:64] ^ w0;
		w2 = rk[63:32] ^ w1;
		w3 = rk[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

	// flags byte, nonce bytes, counter or length in the last l bytes
	function automatic logic [127:0] make_block(input logic [7:0] flags, input logic [31:0] tail,
			input logic [103:0] nonce, input logic [3:0] n, input logic [2:0] l);
		logic [127:0] blk;
		blk = '0;
		blk[127:120] = flags;
		for (int j = 0; j < 13; j++) begin
			if (j < int'(n)) begin
				blk[8*(14-j) +: 8] = nonce[8*(12-j) +: 8];
			end
		end
		for (int i = 0; i < 4; i++) begin
			if (i < int'(l)) begin
				blk[8*i +: 8] = tail[8*i +: 8];
			end
		end
		return blk;
	endfunction

endpackage
`default_nettype wire

// File: design/ccm_front.sv
// input word queue between the accepting side and the ccm sequencer
// depends on ccm_pkg for the input word type
`default_nettype none
module ccm_front #(
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire ccm_pkg::in_t in_data,
	output logic              q_valid,
	output ccm_pkg::in_t      q_data,
	input  wire logic         q_pop
);
	import ccm_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	in_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push, pop;

	assign in_ready = count_q < CW'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_data = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: design/ccm_aes.sv
// iterative aes-128 encryption core, one round per cycle, keys expanded on the fly
// depends on ccm_pkg for the round and key schedule functions
`default_nettype none
module ccm_aes (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] key,
	input  wire logic [127:0] din,
	output logic              done,
	output logic [127:0]      dout
);
	import ccm_pkg::*;

	logic [127:0] s_q, rk_q, rk_next;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic         busy_q, done_q;

	assign rk_next = key_step(rk_q, rc_q);
	assign done = done_q;
	assign dout = s_q;

	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= din ^ key;
			rk_q <= key;
			rc_q <= 8'h01;
		end else if (busy_q) begin
			s_q <= aes_round(s_q, rk_next, rnd_q == 4'd10);
			rk_q <= rk_next;
			rc_q <= xtime(rc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q <= 4'd1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == 4'd10) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: design/ccm_back.sv
// ccm sequencer: classifies each queued word, drives the aes core, emits result words
// depends on ccm_pkg and on the ccm_aes core wired up at the top level
`default_nettype none
module ccm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ccm_pkg::cfg_t cfg,
	input  wire logic          q_valid,
	input  wire ccm_pkg::in_t  q_data,
	output logic               q_pop,
	output logic               aes_start,
	output logic [127:0]       aes_din,
	input  wire logic          aes_done,
	input  wire logic [127:0]  aes_dout,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ccm_pkg::out_t      out_data
);
	import ccm_pkg::*;

	st_t          state_q, state_d;
	op_t          op_q;
	logic         act_q, mis_q, tag_after_q, end_q, out_valid_q;
	logic [7:0]   byte_q;
	logic [32:0]  pos_q;
	logic [31:0]  ctr_q;
	logic [127:0] chain_q, gather_q, ks_q, mask_q;
	logic [3:0]   idx_q;
	out_t         res_q, out_q, out_word;
	logic         out_load;

	logic [3:0]  n_eff;
	logic [4:0]  m_eff, m_less2;
	logic [2:0]  l_len, l_less1;
	logic [7:0]  flags_b0, flags_ctr;
	logic [32:0] h_ext, p_ext, hp, qv, kv;
	logic [3:0]  hdr_o, qo;
	logic        pos_hdr, pos_pay, hdr_last, pay_last, hdr_absorb, pay_absorb;
	logic        cmp_fail, tag_done, slot_free, tag_last;
	logic [7:0]  ks_byte, c_byte, tag_byte;

	assign n_eff = (cfg.nonce_length > MAX_NONCE) ? MAX_NONCE : cfg.nonce_length;
	assign m_eff = (cfg.tag_length < MIN_TAG) ? MIN_TAG :
		(cfg.tag_length > MAX_TAG) ? MAX_TAG : cfg.tag_length;
	assign m_less2 = m_eff - 5'd2;
	assign l_len = (n_eff > SHORT_NONCE) ? 3'(LAST_INDEX - n_eff) : 3'(LAST_INDEX - SHORT_NONCE);
	assign l_less1 = l_len - 3'd1;
	assign flags_b0 = ((cfg.header_length != '0) ? ADATA_FLAG : 8'h00) |
		{2'b00, m_less2[3:1], l_less1};
	assign flags_ctr = {5'b00000, l_less1};

	assign h_ext = 33'(cfg.header_length);
	assign p_ext = 33'(cfg.payload_length);
	assign hp = h_ext + p_ext;
	assign qv = pos_q - h_ext;
	assign kv = pos_q - hp;
	assign qo = qv[3:0];
	assign hdr_o = pos_q[3:0] + 4'd2;
	assign pos_hdr = pos_q < h_ext;
	assign pos_pay = pos_q < hp;
	assign hdr_last = (pos_q + 33'd1) == h_ext;
	assign pay_last = (qv + 33'd1) == p_ext;
	assign hdr_absorb = (hdr_o == LAST_INDEX) || hdr_last;
	assign pay_absorb = (qo == LAST_INDEX) || pay_last;

	assign ks_byte = ks_q[{~qo, 3'b000} +: 8];
	assign c_byte = byte_q ^ ks_byte;
	assign cmp_fail = (kv < 33'(m_eff)) &&
		((byte_q ^ mask_q[{~kv[3:0], 3'b000} +: 8]) != chain_q[{~kv[3:0], 3'b000} +: 8]);
	assign tag_done = (kv + 33'd1) >= 33'(m_eff);
	assign tag_byte = chain_q[{~idx_q, 3'b000} +: 8] ^ mask_q[{~idx_q, 3'b000} +: 8];
	assign tag_last = ({1'b0, idx_q} + 5'd1) == m_eff;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		case (op_q)
			OP_B0:   aes_din = make_block(flags_b0, cfg.payload_length, cfg.nonce, n_eff, l_len);
			OP_A0:   aes_din = make_block(flags_ctr, 32'd0, cfg.nonce, n_eff, l_len);
			OP_CTR:  aes_din = make_block(flags_ctr, ctr_q, cfg.nonce, n_eff, l_len);
			OP_MAC:  aes_din = chain_q ^ gather_q;
			default: aes_din = chain_q ^ gather_q;
		endcase
	end

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		aes_start = 1'b0;
		out_load = 1'b0;
		out_word = res_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					state_d = (pos_q == '0) ? ST_AES_GO : ST_CLASSIFY;
				end
			end
			ST_AES_GO: begin
				aes_start = 1'b1;
				state_d = ST_AES_WAIT;
			end
			ST_AES_WAIT: begin
				if (aes_done) begin
					case (op_q)
						OP_B0:   state_d = ST_AES_GO;
						OP_A0:   state_d = ST_CLASSIFY;
						OP_CTR:  state_d = ST_PAYLOAD;
						OP_MAC:  state_d = ST_EMIT;
						default: state_d = ST_EMIT;
					endcase
				end
			end
			ST_CLASSIFY: begin
				if (pos_hdr) begin
					state_d = hdr_absorb ? ST_AES_GO : ST_EMIT;
				end else if (pos_pay) begin
					state_d = (qo == '0) ? ST_AES_GO : ST_PAYLOAD;
				end else if (!act_q) begin
					state_d = ST_TAG;
				end else begin
					state_d = tag_done ? ST_EMIT : ST_IDLE;
				end
			end
			ST_PAYLOAD: begin
				state_d = pay_absorb ? ST_AES_GO : ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d = tag_after_q ? ST_TAG : ST_IDLE;
				end
			end
			ST_TAG: begin
				out_word = '{out_byte: tag_byte, byte_kind: KIND_TAG, auth_failed: 1'b0,
					last_of_message: tag_last};
				if (slot_free) begin
					out_load = 1'b1;
					if (tag_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// payload registers without reset
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			act_q <= q_data.action;
			byte_q <= q_data.in_byte;
		end
		if (state_q == ST_AES_WAIT && aes_done) begin
			if (op_q == OP_A0) begin
				mask_q <= aes_dout;
			end
			if (op_q == OP_CTR) begin
				ks_q <= aes_dout;
			end
		end
		if (state_q == ST_CLASSIFY) begin
			idx_q <= '0;
			if (pos_hdr) begin
				res_q <= '{out_byte: byte_q, byte_kind: KIND_HEADER, auth_failed: 1'b0,
					last_of_message: 1'b0};
				tag_after_q <= !act_q && (cfg.payload_length == '0) && hdr_last;
				end_q <= 1'b0;
			end else if (!pos_pay) begin
				res_q <= '{out_byte: 8'h00, byte_kind: KIND_STATUS,
					auth_failed: mis_q || cmp_fail, last_of_message: 1'b1};
				tag_after_q <= 1'b0;
				end_q <= 1'b1;
			end
		end
		if (state_q == ST_PAYLOAD) begin
			res_q <= '{out_byte: c_byte, byte_kind: KIND_PAYLOAD, auth_failed: 1'b0,
				last_of_message: 1'b0};
			tag_after_q <= !act_q && pay_last;
			end_q <= 1'b0;
			idx_q <= '0;
		end
		if (state_q == ST_TAG && slot_free) begin
			idx_q <= idx_q + 4'd1;
		end
		if (out_load) begin
			out_q <= out_word;
		end
	end

	// message state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_B0;
			pos_q <= '0;
			ctr_q <= '0;
			mis_q <= 1'b0;
			chain_q <= '0;
			gather_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid && pos_q == '0) begin
						op_q <= OP_B0;
					end
				end
				ST_AES_WAIT: begin
					if (aes_done) begin
						case (op_q)
							OP_B0: begin
								chain_q <= aes_dout;
								gather_q <= (cfg.header_length != '0) ?
									{cfg.header_length, 112'd0} : '0;
								op_q <= OP_A0;
							end
							OP_A0: begin
								ctr_q <= '0;
								mis_q <= 1'b0;
							end
							OP_MAC: begin
								chain_q <= aes_dout;
								gather_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CLASSIFY: begin
					if (pos_hdr) begin
						gather_q[{~hdr_o, 3'b000} +: 8] <= byte_q;
						op_q <= OP_MAC;
					end else if (pos_pay) begin
						if (qo == '0) begin
							ctr_q <= ctr_q + 32'd1;
							op_q <= OP_CTR;
						end
					end else if (act_q) begin
						if (cmp_fail) begin
							mis_q <= 1'b1;
						end
						if (!tag_done) begin
							pos_q <= pos_q + 33'd1;
						end
					end
				end
				ST_PAYLOAD: begin
					gather_q[{~qo, 3'b000} +: 8] <= act_q ? c_byte : byte_q;
					op_q <= OP_MAC;
				end
				ST_EMIT: begin
					if (slot_free) begin
						pos_q <= end_q ? '0 : pos_q + 33'd1;
					end
				end
				ST_TAG: begin
					if (slot_free && tag_last) begin
						pos_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// File: design/aes_ccm_authenticated_cipher_unit.sv
// top level of the aes-128 ccm cipher unit: configuration registers and module wiring
// depends on ccm_pkg, ccm_front, ccm_aes and ccm_back
`default_nettype none
// usage
// - configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key, nonce,
//   nonce length, tag length, header and payload lengths; always ready, write only
//   between messages
// - input channel takes one word per byte: header, payload, then the tag when decrypting
// - output channel gives header words, payload words, tag words or one status word;
//   the final word of a message carries last_of_message
// sequencing and throughput
// - a word waits in a short queue, then the sequencer pops it, classifies it and, for a
//   payload word, forms the cipher byte before emitting the result; each aes-128 run on
//   the shared iterative core goes one round a cycle
// - the first word of a message first runs b0 and then counter block 0; a payload word
//   that opens a counter block runs the keystream block, and a word that closes a mac
//   block runs the mac block
// - encrypting, the tag follows the last data word at one word per cycle while the output is not held
// reset
// - clears the queue, the sequencer and the mac state; configuration returns to its
//   defaults (nonce length 13, tag length 8, all else zero)
// stalls
// - a held output word stalls the sequencer; the queue fills, then in_ready drops
module aes_ccm_authenticated_cipher_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [63:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ccm_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output ccm_pkg::out_t      out_data
);
	import ccm_pkg::*;

	cfg_t         cfg_q;
	logic         q_valid, q_pop;
	in_t          q_data;
	logic         aes_start, aes_done;
	logic [127:0] aes_din, aes_dout;

	// configuration is taken every cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key <= '0;
			cfg_q.nonce <= '0;
			cfg_q.nonce_length <= MAX_NONCE;
			cfg_q.tag_length <= 5'd8;
			cfg_q.header_length <= '0;
			cfg_q.payload_length <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_KEY_HIGH:       cfg_q.key[127:64] <= cfg_data;
				CFG_KEY_LOW:        cfg_q.key[63:0] <= cfg_data;
				CFG_NONCE_HIGH:     cfg_q.nonce[103:64] <= cfg_data[39:0];
				CFG_NONCE_LOW:      cfg_q.nonce[63:0] <= cfg_data;
				CFG_NONCE_LENGTH:   cfg_q.nonce_length <= cfg_data[3:0];
				CFG_TAG_LENGTH:     cfg_q.tag_length <= cfg_data[4:0];
				CFG_HEADER_LENGTH:  cfg_q.header_length <= cfg_data[15:0];
				CFG_PAYLOAD_LENGTH: cfg_q.payload_length <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	// front: input word queue
	ccm_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_pop(q_pop)
	);

	// shared block cipher for mac, counter blocks and b0
	ccm_aes u_aes (
		.clk(clk),
		.arst_n(arst_n),
		.start(aes_start),
		.key(cfg_q.key),
		.din(aes_din),
		.done(aes_done),
		.dout(aes_dout)
	);

	// back: sequencer and output register
	ccm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_pop(q_pop),
		.aes_start(aes_start),
		.aes_din(aes_din),
		.aes_done(aes_done),
		.aes_dout(aes_dout),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

endmodule
`default_nettype wire

// File: tb/tb_aes_ccm_authenticated_cipher_unit.sv
// testbench for the aes-128 ccm cipher unit: directed and random messages, checked word by word
// depends on ccm_pkg and aes_ccm_authenticated_cipher_unit; a scoreboard class predicts results
`default_nettype none
module tb_aes_ccm_authenticated_cipher_unit;
	import ccm_pkg::*;

	typedef bit [7:0] blk_t [16];

	// ccm predictor and store of expected output words
	class ccm_scoreboard;
		bit [63:0] key_hi, key_lo, nonce_hi, nonce_lo;
		bit [3:0]  nonce_len;
		bit [4:0]  tag_len;
		bit [15:0] hdr_len;
		bit [31:0] pay_len;
		blk_t      chain, gather, kstream, mask;
		bit [31:0] counter;
		longint unsigned pos;
		bit        mismatch;
		out_t      pending [$];
		int        errors;

		function new();
			key_hi = '0;
			key_lo = '0;
			nonce_hi = '0;
			nonce_lo = '0;
			nonce_len = 4'd13;
			tag_len = 5'd8;
			hdr_len = '0;
			pay_len = '0;
			foreach (chain[i]) begin
				chain[i] = 0;
				gather[i] = 0;
				kstream[i] = 0;
				mask[i] = 0;
			end
			counter = 0;
			pos = 0;
			mismatch = 0;
			errors = 0;
		endfunction

		function void report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endfunction

		function void write_reg(bit [2:0] idx, bit [63:0] v);
			case (idx)
				CFG_KEY_HIGH: key_hi = v;
				CFG_KEY_LOW: key_lo = v;
				CFG_NONCE_HIGH: nonce_hi = {24'd0, v[39:0]};
				CFG_NONCE_LOW: nonce_lo = v;
				CFG_NONCE_LENGTH: nonce_len = v[3:0];
				CFG_TAG_LENGTH: tag_len = v[4:0];
				CFG_HEADER_LENGTH: hdr_len = v[15:0];
				CFG_PAYLOAD_LENGTH: pay_len = v[31:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_n();
			return (nonce_len > 13) ? 32'd13 : 32'(nonce_len);
		endfunction

		function int unsigned eff_m();
			if (tag_len < 4) return 4;
			if (tag_len > 16) return 16;
			return 32'(tag_len);
		endfunction

		function int unsigned span();
			int unsigned n;
			n = eff_n();
			return 15 - ((n > 11) ? n : 11);
		endfunction

		function bit [7:0] gf_double(bit [7:0] v);
			return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
		endfunction

		function blk_t aes(blk_t in_blk);
			bit [7:0] rk [176];
			bit [7:0] s [16];
			bit [7:0] t [16];
			bit [7:0] tmp [4];
			bit [7:0] rc, first, a0, a1, a2, a3, all;
			blk_t res;
			rc = 8'h01;
			for (int i = 0; i < 8; i++) begin
				rk[i] = key_hi[8*(7-i) +: 8];
				rk[8+i] = key_lo[8*(7-i) +: 8];
			end
			for (int i = 16; i < 176; i += 4) begin
				for (int j = 0; j < 4; j++) tmp[j] = rk[i-4+j];
				if (i % 16 == 0) begin
					first = tmp[0];
					tmp[0] = SBOX[tmp[1]] ^ rc;
					tmp[1] = SBOX[tmp[2]];
					tmp[2] = SBOX[tmp[3]];
					tmp[3] = SBOX[first];
					rc = gf_double(rc);
				end
				for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ tmp[j];
			end
			for (int i = 0; i < 16; i++) s[i] = in_blk[i] ^ rk[i];
			for (int r = 1; r <= 10; r++) begin
				for (int c = 0; c < 4; c++)
					for (int j = 0; j < 4; j++) t[c*4+j] = SBOX[s[((c+j)%4)*4+j]];
				if (r != 10) begin
					for (int c = 0; c < 4; c++) begin
						a0 = t[c*4];
						a1 = t[c*4+1];
						a2 = t[c*4+2];
						a3 = t[c*4+3];
						all = a0 ^ a1 ^ a2 ^ a3;
						t[c*4] = a0 ^ all ^ gf_double(a0 ^ a1);
						t[c*4+1] = a1 ^ all ^ gf_double(a1 ^ a2);
						t[c*4+2] = a2 ^ all ^ gf_double(a2 ^ a3);
						t[c*4+3] = a3 ^ all ^ gf_double(a3 ^ a0);
					end
				end
				for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16+i];
			end
			for (int i = 0; i < 16; i++) res[i] = s[i];
			return res;
		endfunction

		// flags, nonce bytes, then a value in the last l bytes
		function blk_t form_block(bit [7:0] flags, bit [31:0] tail);
			blk_t blk;
			int unsigned n, l;
			n = eff_n();
			l = span();
			foreach (blk[i]) blk[i] = 0;
			blk[0] = flags;
			for (int i = 0; i < n; i++)
				blk[1+i] = (i < 5) ? nonce_hi[8*(4-i) +: 8] : nonce_lo[8*(12-i) +: 8];
			for (int i = 0; i < l; i++) blk[15-i] = tail[8*i +: 8];
			return blk;
		endfunction

		function void absorb();
			for (int k = 0; k < 16; k++) chain[k] ^= gather[k];
			chain = aes(chain);
			foreach (gather[i]) gather[i] = 0;
		endfunction

		function void open_message();
			bit [7:0] flags;
			int unsigned m, l;
			m = eff_m();
			l = span();
			flags = ((hdr_len != 0) ? ADATA_FLAG : 8'h00) |
				8'((((m - 2) >> 1) & 7) << 3) | 8'(l - 1);
			chain = aes(form_block(flags, pay_len));
			foreach (gather[i]) gather[i] = 0;
			if (hdr_len != 0) begin
				gather[0] = hdr_len[15:8];
				gather[1] = hdr_len[7:0];
			end
			mask = aes(form_block(8'(l - 1), 32'd0));
			counter = 0;
			mismatch = 0;
		endfunction

		function void push(bit [7:0] b, bit [1:0] kind, bit fail, bit last);
			out_t e;
			e.out_byte = b;
			e.byte_kind = kind;
			e.auth_failed = fail;
			e.last_of_message = last;
			pending.push_back(e);
		endfunction

		function void append_tag();
			int unsigned m;
			m = eff_m();
			for (int k = 0; k < m; k++) push(chain[k] ^ mask[k], KIND_TAG, 1'b0, k + 1 == m);
			pos = 0;
		endfunction

		function bit [7:0] tag_byte(int k);
			return chain[k] ^ mask[k];
		endfunction

		function void note_input(in_t w);
			bit dec;
			bit [7:0] b, c;
			longint unsigned h, p, q, k;
			int unsigned o, m;
			dec = w.action;
			b = w.in_byte;
			h = hdr_len;
			p = pay_len;
			m = eff_m();
			if (pos == 0) open_message();
			if (pos < h) begin
				o = 32'((pos + 2) % 16);
				gather[o] = b;
				if (o == 15 || pos + 1 == h) absorb();
				push(b, KIND_HEADER, 1'b0, 1'b0);
				if (!dec && p == 0 && pos + 1 == h) append_tag();
				else pos++;
				return;
			end
			if (pos < h + p) begin
				q = pos - h;
				o = 32'(q % 16);
				if (o == 0) begin
					counter++;
					kstream = aes(form_block(8'(span() - 1), counter));
				end
				c = b ^ kstream[o];
				gather[o] = dec ? c : b;
				if (o == 15 || q + 1 == p) absorb();
				push(c, KIND_PAYLOAD, 1'b0, 1'b0);
				if (!dec && q + 1 == p) append_tag();
				else pos++;
				return;
			end
			if (!dec) begin
				append_tag();
				return;
			end
			k = pos - h - p;
			if (k < m && (b ^ mask[k % 16]) != chain[k % 16]) mismatch = 1'b1;
			if (k + 1 >= m) begin
				push(8'h00, KIND_STATUS, mismatch, 1'b1);
				pos = 0;
			end else begin
				pos++;
			end
		endfunction

		function void check_word(out_t got);
			out_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected word %h", got));
				return;
			end
			e = pending.pop_front();
			if (got.out_byte !== e.out_byte)
				report($sformatf("out_byte %h, expected %h", got.out_byte, e.out_byte));
			if (got.byte_kind !== e.byte_kind)
				report($sformatf("byte_kind %0d, expected %0d", got.byte_kind, e.byte_kind));
			if (got.auth_failed !== e.auth_failed)
				report($sformatf("auth_failed %b, expected %b", got.auth_failed, e.auth_failed));
			if (got.last_of_message !== e.last_of_message)
				report($sformatf("last_of_message %b, expected %b",
					got.last_of_message, e.last_of_message));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;

	ccm_scoreboard sb;
	int  n_words;       // input words accepted so far
	bit  no_idle;       // both sides run flat out while set
	bit  hold_req;      // asks the receiver for one long hold-off
	int  hold_left;

	aes_ccm_authenticated_cipher_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// free running clock, period 20
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#20000000;
		$display("FAILURE");
		$finish;
	end

	// receiver: check every accepted word, then pick next ready
	// a hold request turns into a long run of cycles with ready low, counted here
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_word(out_data);
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(99) >= 21);
		end
	end

	// one configuration write; valid stays up so back-to-back writes need no re-raise
	task automatic cfg_write(bit [2:0] idx, bit [63:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
	endtask

	// offer one input word, hold it until taken, then log it with the predictor
	task automatic send_word(bit act, bit [7:0] b);
		in_t w;
		w.action = act;
		w.in_byte = b;
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_input(w);
		n_words++;
		// random gap before the next word
		if (!no_idle && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// drain: all expected words out, then room for words that cause no result
	task automatic settle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	function automatic bit [63:0] pick_wide(int bits);
		bit [63:0] v;
		case ($urandom_range(3))
			0: v = '0;
			1: v = '1;
			default: v = {$urandom, $urandom};
		endcase
		return (bits == 64) ? v : (v & ((64'd1 << bits) - 1));
	endfunction

	// one whole message; a decrypt run ends with the tag, correct or with one bit flipped
	task automatic run_message(bit act, int h, int p, bit bad_tag);
		int m, bad_k;
		bit [7:0] tb;
		cfg_write(CFG_HEADER_LENGTH, 64'(h));
		cfg_write(CFG_PAYLOAD_LENGTH, 64'(p));
		cfg_valid <= 1'b0;
		for (int i = 0; i < h + p; i++) send_word(act, 8'($urandom_range(255)));
		if (act) begin
			m = sb.eff_m();
			bad_k = $urandom_range(m - 1);
			for (int k = 0; k < m; k++) begin
				// with no data the mask is only known once the first word is in
				tb = (h + p == 0) ? 8'($urandom_range(255)) : sb.tag_byte(k);
				if (bad_tag && k == bad_k) tb ^= 8'h01 << $urandom_range(7);
				send_word(act, tb);
			end
		end else if (h + p == 0) begin
			// empty encrypt: the word is dropped and only the tag comes out
			send_word(act, 8'($urandom_range(255)));
		end
		in_valid <= 1'b0;
		settle();
	endtask

	task automatic random_setup(bit all);
		if (all || $urandom_range(1)) cfg_write(CFG_KEY_HIGH, pick_wide(64));
		if (all || $urandom_range(1)) cfg_write(CFG_KEY_LOW, pick_wide(64));
		if (all || $urandom_range(1)) cfg_write(CFG_NONCE_HIGH, pick_wide(40));
		if (all || $urandom_range(1)) cfg_write(CFG_NONCE_LOW, pick_wide(64));
		if (all || $urandom_range(1)) cfg_write(CFG_NONCE_LENGTH, 64'($urandom_range(15)));
		if (all || $urandom_range(1)) cfg_write(CFG_TAG_LENGTH, 64'($urandom_range(31)));
	endtask

	initial begin
		int h, p, msg;
		bit act;
		sb = new();
		n_words = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_ready <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: empty encrypt on reset settings
		run_message(1'b0, 0, 0, 1'b0);
		// all-ones key and nonce, nonce length past 13, tag length past 16
		cfg_write(CFG_KEY_HIGH, '1);
		cfg_write(CFG_KEY_LOW, '1);
		cfg_write(CFG_NONCE_HIGH, 64'hff_ffff_ffff);
		cfg_write(CFG_NONCE_LOW, '1);
		cfg_write(CFG_NONCE_LENGTH, 64'd15);
		cfg_write(CFG_TAG_LENGTH, 64'd31);
		run_message(1'b0, 1, 0, 1'b0);
		// short nonce, tag length below 4, good tag on decrypt
		cfg_write(CFG_KEY_HIGH, '0);
		cfg_write(CFG_NONCE_LENGTH, 64'd0);
		cfg_write(CFG_TAG_LENGTH, 64'd0);
		run_message(1'b1, 2, 3, 1'b0);
		// odd tag length, corrupted tag
		cfg_write(CFG_NONCE_LENGTH, 64'd11);
		cfg_write(CFG_TAG_LENGTH, 64'd5);
		run_message(1'b1, 0, 1, 1'b1);

		// random messages, mostly well formed with short lengths
		msg = 0;
		while (n_words < 230) begin
			random_setup(msg == 0);
			act = 1'($urandom_range(1));
			h = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
			p = ($urandom_range(7) == 0) ? $urandom_range(41, 60) : $urandom_range(0, 40);
			if (!act && h == 0 && p == 0 && $urandom_range(3) != 0) p = 1;
			no_idle = (msg >= 2 && msg <= 4);
			// one long receiver hold while the sender keeps pushing a long message
			if (msg == 6) begin
				hold_req = 1'b1;
				p = 48;
			end
			run_message(act, h, p, $urandom_range(2) == 0);
			msg++;
		end
		no_idle = 1'b0;

		settle();
		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
`default_nettype wire
